### rtl/core/krlp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the kth ranked linear position block.
// No dependencies; imported by every module of the block.
package krlp_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W        = 11;
  localparam int VAL_W       = 32;
  localparam int TIME_W      = 31;
  localparam int POS_W       = 64;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [VAL_W-1:0] speed;
    logic signed [VAL_W-1:0] start_pos;
    logic [TIME_W-1:0]       time_value;
    logic [ID_W-1:0]         rank;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] object_id;
    logic            rank_invalid;
  } out_item_t;

  // One beat on the cell chain: a position on its way to its own cell,
  // or, once done is set, the answer on its way to the chain tail.
  typedef struct packed {
    logic                    valid;
    logic                    last;
    logic                    done;
    logic                    found;
    logic [IDX_W-1:0]        cnt;
    logic [ID_W-1:0]         res;
    logic signed [POS_W-1:0] pos;
  } beat_t;

endpackage

### rtl/core/krlp_store.sv
`timescale 1ns / 1ps
// Object table memory and the position pipeline feeding the cell chain.
// Depends on krlp_pkg.
module krlp_store (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [krlp_pkg::IDX_W-1:0]       waddr_i,
  input  logic signed [krlp_pkg::VAL_W-1:0] wspeed_i,
  input  logic signed [krlp_pkg::VAL_W-1:0] wstart_i,
  input  logic                             re_i,
  input  logic [krlp_pkg::IDX_W-1:0]       raddr_i,
  input  logic                             rlast_i,
  input  logic [krlp_pkg::TIME_W-1:0]      time_i,
  output krlp_pkg::beat_t                  head_o
);
  import krlp_pkg::*;

  logic [VAL_W-1:0] speed_mem [MAX_ENTRIES];
  logic [VAL_W-1:0] start_mem [MAX_ENTRIES];

  logic [VAL_W-1:0]        spd_q, sta_q, sta2_q;
  logic                    v1_q, last1_q, v2_q, last2_q;
  logic signed [POS_W-1:0] prod_q;
  logic signed [POS_W-1:0] prod_d;
  beat_t                   head_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      speed_mem[waddr_i] <= wspeed_i;
      start_mem[waddr_i] <= wstart_i;
    end
    if (re_i) begin
      spd_q <= speed_mem[raddr_i];
      sta_q <= start_mem[raddr_i];
    end
  end

  // 32 x 32 signed product; time is non-negative
  assign prod_d = $signed(spd_q) * $signed({1'b0, time_i});

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sta2_q <= sta_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
      v2_q    <= 1'b0;
      last2_q <= 1'b0;
      head_q  <= '0;
    end else begin
      v1_q         <= re_i;
      last1_q      <= rlast_i;
      v2_q         <= v1_q;
      last2_q      <= last1_q;
      head_q.valid <= v2_q;
      head_q.last  <= last2_q;
      head_q.done  <= 1'b0;
      head_q.found <= 1'b0;
      head_q.cnt   <= '0;
      head_q.res   <= '0;
      head_q.pos   <= prod_q + {{(POS_W-VAL_W){sta2_q[VAL_W-1]}}, sta2_q};
    end
  end

  assign head_o = head_q;

endmodule

### rtl/core/krlp_cell.sv
`timescale 1ns / 1ps
// One ranking cell: captures the first position that reaches it, counts
// later positions ahead of it and adds its own vote to passing ones.
// Depends on krlp_pkg.
module krlp_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic [krlp_pkg::IDX_W-1:0] km1_i,
  input  logic [krlp_pkg::ID_W-1:0]  my_id_i,
  input  krlp_pkg::beat_t            in_i,
  output krlp_pkg::beat_t            out_o
);
  import krlp_pkg::*;

  logic                    occ_q, occ_d;
  logic [IDX_W-1:0]        cnt_q, cnt_d, own;
  logic signed [POS_W-1:0] pos_q, pos_d;
  beat_t                   out_q, out_d;
  logic                    ahead;

  always_comb begin
    occ_d       = occ_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    out_d       = in_i;
    out_d.valid = 1'b0;
    // passing beat has a higher id, so a tie stays behind the held one
    ahead       = $signed(in_i.pos) > $signed(pos_q);
    own         = cnt_q + IDX_W'(ahead);
    if (in_i.valid) begin
      if (in_i.done) begin
        out_d = in_i;
      end else if (!occ_q) begin
        occ_d = 1'b1;
        pos_d = in_i.pos;
        cnt_d = in_i.cnt;
        if (in_i.last) begin
          out_d      = in_i;
          out_d.done = 1'b1;
          if (!in_i.found) begin
            out_d.found = 1'b1;
            out_d.res   = my_id_i;
          end
        end
      end else begin
        cnt_d     = own;
        out_d     = in_i;
        out_d.cnt = in_i.cnt + IDX_W'(!ahead);
        if (in_i.last && !in_i.found && own == km1_i) begin
          out_d.found = 1'b1;
          out_d.res   = my_id_i;
        end
      end
    end
    if (clear_i) begin
      occ_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      out_q <= '0;
    end else begin
      occ_q <= occ_d;
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    pos_q <= pos_d;
  end

  assign out_o = out_q;

endmodule

### rtl/core/kth_ranked_linear_position.sv
`timescale 1ns / 1ps
// Top level of the kth ranked linear position block; uses krlp_pkg, krlp_store, krlp_cell.
// Clear and load leave busy low. A query with rank zero or above the stored count
// answers in the cycle after the start beat. Any other query keeps busy high while
// the n stored objects pass one a cycle through the shared multiplier and the last
// position walks through all cells.
// Reset empties the table; the result strobe fires once per query and cannot be stalled.
module kth_ranked_linear_position (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  krlp_pkg::in_item_t  item_i,
  output logic                done_o,
  output krlp_pkg::out_item_t result_o
);
  import krlp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_WAIT
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic [IDX_W-1:0]  km1_q;
  logic [TIME_W-1:0] t_q;
  logic              done_q;
  out_item_t         result_q;

  logic              accept;
  logic              load_ok;
  logic              rank_bad;
  logic              mem_we;
  logic              rd_en;
  logic              rd_last;
  logic              clear_cells;

  beat_t             link [MAX_ENTRIES+1];

  assign accept   = start && (state_q == ST_IDLE);
  assign load_ok  = count_q < CNT_W'(MAX_ENTRIES);
  assign rank_bad = (item_i.rank == '0) || (item_i.rank > ID_W'(count_q));
  assign rd_last  = (CNT_W'(rd_idx_q) + CNT_W'(1)) == count_q;

  always_comb begin
    mem_we      = 1'b0;
    clear_cells = 1'b0;
    if (accept) begin
      mem_we      = (item_i.mode == MODE_LOAD) && load_ok;
      clear_cells = (item_i.mode == MODE_QUERY) && !rank_bad;
    end
    rd_en = (state_q == ST_FEED);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      rd_idx_q <= '0;
      km1_q    <= '0;
      t_q      <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            unique case (item_i.mode)
              MODE_CLEAR: begin
                count_q <= '0;
              end
              MODE_LOAD: begin
                if (load_ok) begin
                  count_q <= count_q + CNT_W'(1);
                end
              end
              MODE_QUERY: begin
                if (rank_bad) begin
                  // answer at once, no walk through the chain
                  done_q                <= 1'b1;
                  result_q.object_id    <= '0;
                  result_q.rank_invalid <= 1'b1;
                end else begin
                  km1_q    <= IDX_W'(item_i.rank - ID_W'(1));
                  t_q      <= item_i.time_value;
                  rd_idx_q <= '0;
                  state_q  <= ST_FEED;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_FEED: begin
          // advance one stored object a cycle into the position pipeline
          rd_idx_q <= rd_idx_q + IDX_W'(1);
          if (rd_last) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          // hold until the answer beat leaves the last cell
          if (link[MAX_ENTRIES].valid && link[MAX_ENTRIES].done) begin
            done_q                <= 1'b1;
            result_q.object_id    <= link[MAX_ENTRIES].res;
            result_q.rank_invalid <= 1'b0;
            state_q               <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  krlp_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (mem_we),
    .waddr_i  (count_q[IDX_W-1:0]),
    .wspeed_i (item_i.speed),
    .wstart_i (item_i.start_pos),
    .re_i     (rd_en),
    .raddr_i  (rd_idx_q),
    .rlast_i  (rd_en && rd_last),
    .time_i   (t_q),
    .head_o   (link[0])
  );

  // Cell i ends up holding object i+1; each position walks right until it
  // finds an empty cell, and the last one turns into the answer beat there.
  for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
    krlp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (clear_cells),
      .km1_i   (km1_q),
      .my_id_i (ID_W'(gi + 1)),
      .in_i    (link[gi]),
      .out_o   (link[gi+1])
    );
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

### rtl/core/krlp_checker.sv
`timescale 1ns / 1ps
// Port-level checks over time for kth_ranked_linear_position, bound to the top.
// Depends on krlp_pkg.
module krlp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input krlp_pkg::in_item_t  item_i,
  input logic                done_o,
  input krlp_pkg::out_item_t result_o
);
  import krlp_pkg::*;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while busy");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.rank_invalid) |-> (result_o.object_id == '0))
    else $error("invalid result with nonzero id");

  a_valid_id : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.rank_invalid) |->
      (result_o.object_id != '0) && (result_o.object_id <= ID_W'(MAX_ENTRIES)))
    else $error("valid result with id out of range");

  a_rank_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.mode == MODE_QUERY && item_i.rank == '0) |=>
      (done_o && result_o.rank_invalid && !busy))
    else $error("rank zero query not answered invalid at once");

  a_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.mode != MODE_QUERY) |=> (!done_o && !busy))
    else $error("clear or load gave a result or stalled");

endmodule

bind kth_ranked_linear_position krlp_checker u_krlp_checker (.*);
